### hw/rtl/cusum_pkg.sv
// shared constants for the cusum anomaly detector
`default_nettype none

package cusum_pkg;

  // parameter defaults
  localparam int WINDOW_MAX_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int SUM_BITS_DEF    = 24;

  // register field widths
  localparam int WLEN_W = 5;
  localparam int DEV_W  = 16;

  // register reset values
  localparam logic [WLEN_W-1:0] DEF_WINDOW_LENGTH = 5'd3;
  localparam logic [DEV_W-1:0]  DEF_DEVIATION     = 16'd205;

  // apb register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_DEVIATION     = 1'b1;

  // quotient bits retired per divider cycle
  localparam int DIV_DIGIT_BITS = 4;

endpackage

`default_nettype wire

### hw/rtl/cusum_ring.sv
// sample ring memory, one write port and one registered read port
`default_nettype none

module cusum_ring #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= store_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/cusum_div.sv
// iterative signed-by-unsigned divider, truncating toward zero
`default_nettype none

module cusum_div
  import cusum_pkg::*;
#(
  parameter int NUM_W = 21,
  parameter int DEN_W = 5
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic        [DEN_W-1:0] den_i,
  output logic                         done_o,
  output logic signed      [NUM_W-1:0] quo_o
);

  localparam int PAD_W = ((NUM_W + DIV_DIGIT_BITS - 1) / DIV_DIGIT_BITS) * DIV_DIGIT_BITS;
  localparam int STEPS = PAD_W / DIV_DIGIT_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy_q, busy_d;
  logic             fin_q, fin_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PAD_W-1:0] shf_q, shf_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic             neg_q, neg_d;
  logic signed [NUM_W-1:0] quo_q, quo_d;

  logic [NUM_W-1:0] mag;
  logic [PAD_W-1:0] step_shf;
  logic [DEN_W-1:0] step_rem;

  assign mag = num_i[NUM_W-1] ? (~num_i + NUM_W'(1)) : num_i;

  // one radix-16 digit: four restoring steps on a narrow remainder
  always_comb begin
    logic [DEN_W:0]   trial;
    logic [PAD_W-1:0] s;
    logic [DEN_W-1:0] r;
    s = shf_q;
    r = rem_q;
    for (int j = 0; j < DIV_DIGIT_BITS; j++) begin
      trial = {r, s[PAD_W-1]};
      s = {s[PAD_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        r    = DEN_W'(trial - {1'b0, den_q});
        s[0] = 1'b1;
      end else begin
        r = trial[DEN_W-1:0];
      end
    end
    step_shf = s;
    step_rem = r;
  end

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    shf_d  = shf_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(STEPS);
      shf_d  = PAD_W'(mag);
      rem_d  = '0;
      den_d  = den_i;
      neg_d  = num_i[NUM_W-1];
    end else if (busy_q) begin
      shf_d = step_shf;
      rem_d = step_rem;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
    if (fin_q) begin
      quo_d  = neg_q ? -signed'(shf_q[NUM_W-1:0]) : signed'(shf_q[NUM_W-1:0]);
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shf_q <= shf_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

### hw/rtl/cusum_anomaly_detector_core.sv
// top level of the two-sided cusum anomaly detector
//
// usage:
//   input channel: sample_i with in_valid_i / in_ready_o; output channel:
//   ready_res_o, upper_sum_o, lower_sum_o, anomaly_o with out_valid_o /
//   out_ready_i. every accepted item gives exactly one result item.
//   an apb port holds window_length (offset 0x0) and deviation (0x4);
//   any register write clears the ring fill, the window sum and both
//   accumulators, and must only happen while the block is idle.
//   items go one at a time. a warm-up item (ring not yet full) goes from
//   accept straight to the result stage. a steady item reads the evicted
//   sample from the ring, starts the mean divider (four quotient bits per
//   cycle), waits for the divider to hand over the quotient, forms the
//   deviation, clamps both accumulators and then writes the result; the
//   next item is accepted once the block is back in idle after that write.
//   the result sits in an output register, so the next item is accepted
//   and worked on while the previous result waits; a stalled receiver only
//   holds the block once the next result is ready to be written.
//   reset clears control state and loads the default registers; the ring
//   memory needs no clearing pass, as entries are written before read.
`default_nettype none

module cusum_anomaly_detector_core
  import cusum_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int SUM_BITS    = SUM_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // sample channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               ready_res_o,
  output logic             [SUM_BITS-1:0]    upper_sum_o,
  output logic signed      [SUM_BITS:0]      lower_sum_o,
  output logic                               anomaly_o,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic        [APB_ADDR_W-1:0]  paddr,
  input  wire logic        [APB_DATA_W-1:0]  pwdata,
  output logic             [APB_DATA_W-1:0]  prdata,
  output logic                               pready
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUMW  = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1;
  localparam int MAX_A = (SUM_BITS > SUMW) ? SUM_BITS : SUMW;
  localparam int MAX_B = (MAX_A > DEV_W + 3) ? MAX_A : DEV_W + 3;
  localparam int ACC_W = MAX_B + 2;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_DSTART = 3'd2;
  localparam logic [2:0] ST_DWAIT  = 3'd3;
  localparam logic [2:0] ST_ACC    = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  // configuration
  logic [WLEN_W-1:0] window_length_q, window_length_d;
  logic [DEV_W-1:0]  deviation_q, deviation_d;

  // control state
  logic [2:0]              state_q, state_d;
  logic [LEN_W-1:0]        fill_q, fill_d;
  logic [IDX_W-1:0]        wi_q, wi_d;
  logic signed [SUMW-1:0]  sum_q, sum_d;
  logic [SUM_BITS-1:0]     up_q, up_d;
  logic [SUM_BITS-1:0]     dn_q, dn_d;
  logic                    out_valid_q, out_valid_d;

  // per-item payload
  logic signed [SAMPLE_BITS-1:0] x_q, x_d;
  logic                          warm_q, warm_d;
  logic signed [ACC_W-1:0]       dp_q, dp_d;
  logic signed [ACC_W-1:0]       dm_q, dm_d;
  logic [SUM_BITS-1:0]           up_new_q, up_new_d;
  logic [SUM_BITS-1:0]           dn_new_q, dn_new_d;

  // result register
  logic                       ready_res_q, ready_res_d;
  logic [SUM_BITS-1:0]        upper_q, upper_d;
  logic signed [SUM_BITS:0]   lower_q, lower_d;
  logic                       anomaly_q, anomaly_d;

  logic [LEN_W-1:0]       eff_len;
  logic [LEN_W-1:0]       wi_inc;
  logic [IDX_W-1:0]       wi_next;
  logic                   warm_now;
  logic                   accept;
  logic                   cfg_we;
  logic                   out_free;
  logic                   mem_we;
  logic                   mem_re;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic [SAMPLE_BITS-1:0] mem_rdata;
  logic                   div_start;
  logic                   div_done;
  logic signed [SUMW-1:0] div_quo;
  logic signed [SUMW-1:0] sample_ext;
  logic signed [SUMW-1:0] x_ext;
  logic signed [SUMW-1:0] old_ext;
  logic signed [ACC_W-1:0] up_raw;
  logic signed [ACC_W-1:0] dn_raw;
  logic [ACC_W-1:0]       cap_ext;
  logic [ACC_W-1:0]       thr_ext;
  logic [DEV_W+2:0]       thr;

  // window length of zero acts as one, beyond the ring depth as the depth
  always_comb begin
    if (window_length_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(window_length_q) > WINDOW_MAX) begin
      eff_len = LEN_W'(WINDOW_MAX);
    end else begin
      eff_len = LEN_W'(window_length_q);
    end
  end

  assign wi_inc  = LEN_W'(wi_q) + LEN_W'(1);
  assign wi_next = (wi_inc >= eff_len) ? '0 : IDX_W'(wi_inc);

  assign warm_now   = fill_q < eff_len;
  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign cfg_we     = psel && penable && pwrite;
  assign out_free   = !out_valid_q || out_ready_i;
  assign pready     = 1'b1;

  assign sample_ext = {{(SUMW-SAMPLE_BITS){sample_i[SAMPLE_BITS-1]}}, sample_i};
  assign x_ext      = {{(SUMW-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q};
  assign old_ext    = {{(SUMW-SAMPLE_BITS){mem_rdata[SAMPLE_BITS-1]}}, mem_rdata};

  // ring access: warm-up writes on accept, steady items read on accept
  // and write back the new sample once the evicted one is out
  assign mem_we    = (accept && warm_now) || (state_q == ST_READ);
  assign mem_re    = accept && !warm_now;
  assign mem_wdata = (state_q == ST_READ) ? x_q : sample_i;

  assign div_start = state_q == ST_DSTART;

  // five times deviation, as a shift and an add
  assign thr     = {1'b0, deviation_q, 2'b00} + {3'b000, deviation_q};
  assign thr_ext = ACC_W'(thr);
  assign cap_ext = {{(ACC_W-SUM_BITS){1'b0}}, {SUM_BITS{1'b1}}};

  assign up_raw = signed'({{(ACC_W-SUM_BITS){1'b0}}, up_q}) + dp_q;
  assign dn_raw = signed'({{(ACC_W-SUM_BITS){1'b0}}, dn_q}) + dm_q;

  always_comb begin
    logic signed [ACC_W-1:0] xe;
    logic signed [ACC_W-1:0] me;
    logic signed [ACC_W-1:0] ke;
    xe = {{(ACC_W-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q};
    me = {{(ACC_W-SUMW){div_quo[SUMW-1]}}, div_quo};
    ke = signed'({{(ACC_W-DEV_W+1){1'b0}}, deviation_q[DEV_W-1:1]});

    window_length_d = window_length_q;
    deviation_d     = deviation_q;
    state_d         = state_q;
    fill_d          = fill_q;
    wi_d            = wi_q;
    sum_d           = sum_q;
    up_d            = up_q;
    dn_d            = dn_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    x_d             = x_q;
    warm_d          = warm_q;
    dp_d            = dp_q;
    dm_d            = dm_q;
    up_new_d        = up_new_q;
    dn_new_d        = dn_new_q;
    ready_res_d     = ready_res_q;
    upper_d         = upper_q;
    lower_d         = lower_q;
    anomaly_d       = anomaly_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          x_d    = sample_i;
          warm_d = warm_now;
          if (warm_now) begin
            sum_d   = sum_q + sample_ext;
            fill_d  = fill_q + LEN_W'(1);
            wi_d    = wi_next;
            state_d = ST_FIN;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        // evicted sample is on the read port now
        sum_d   = sum_q - old_ext + x_ext;
        wi_d    = wi_next;
        state_d = ST_DSTART;
      end
      ST_DSTART: begin
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          dp_d    = xe - me - ke;
          dm_d    = me - xe - ke;
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        // clamp at zero below and at the accumulator width above
        if (up_raw[ACC_W-1]) begin
          up_new_d = '0;
        end else if (unsigned'(up_raw) > cap_ext) begin
          up_new_d = '1;
        end else begin
          up_new_d = up_raw[SUM_BITS-1:0];
        end
        if (dn_raw[ACC_W-1]) begin
          dn_new_d = '0;
        end else if (unsigned'(dn_raw) > cap_ext) begin
          dn_new_d = '1;
        end else begin
          dn_new_d = dn_raw[SUM_BITS-1:0];
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (warm_q) begin
            ready_res_d = 1'b0;
            upper_d     = '0;
            lower_d     = '0;
            anomaly_d   = 1'b0;
          end else begin
            ready_res_d = 1'b1;
            upper_d     = up_new_q;
            lower_d     = -signed'({1'b0, dn_new_q});
            anomaly_d   = (ACC_W'(up_new_q) > thr_ext) || (ACC_W'(dn_new_q) > thr_ext);
            up_d        = up_new_q;
            dn_d        = dn_new_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // any register write restarts the window and the accumulators
    if (cfg_we) begin
      unique case (paddr[2])
        REG_WINDOW_LENGTH: window_length_d = pwdata[WLEN_W-1:0];
        REG_DEVIATION:     deviation_d     = pwdata[DEV_W-1:0];
        default:           window_length_d = window_length_q;
      endcase
      fill_d = '0;
      wi_d   = '0;
      sum_d  = '0;
      up_d   = '0;
      dn_d   = '0;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_LENGTH: prdata = {{(APB_DATA_W-WLEN_W){1'b0}}, window_length_q};
      REG_DEVIATION:     prdata = {{(APB_DATA_W-DEV_W){1'b0}}, deviation_q};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= DEF_WINDOW_LENGTH;
      deviation_q     <= DEF_DEVIATION;
      state_q         <= ST_IDLE;
      fill_q          <= '0;
      wi_q            <= '0;
      sum_q           <= '0;
      up_q            <= '0;
      dn_q            <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      window_length_q <= window_length_d;
      deviation_q     <= deviation_d;
      state_q         <= state_d;
      fill_q          <= fill_d;
      wi_q            <= wi_d;
      sum_q           <= sum_d;
      up_q            <= up_d;
      dn_q            <= dn_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    warm_q      <= warm_d;
    dp_q        <= dp_d;
    dm_q        <= dm_d;
    up_new_q    <= up_new_d;
    dn_new_q    <= dn_new_d;
    ready_res_q <= ready_res_d;
    upper_q     <= upper_d;
    lower_q     <= lower_d;
    anomaly_q   <= anomaly_d;
  end

  cusum_ring #(
    .DEPTH  (WINDOW_MAX),
    .WIDTH  (SAMPLE_BITS),
    .ADDR_W (IDX_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wi_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (wi_q),
    .rdata_o (mem_rdata)
  );

  // mean of the window, truncated toward zero
  cusum_div #(
    .NUM_W (SUMW),
    .DEN_W (LEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_q),
    .den_i   (eff_len),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign ready_res_o = ready_res_q;
  assign upper_sum_o = upper_q;
  assign lower_sum_o = lower_q;
  assign anomaly_o   = anomaly_q;

endmodule

`default_nettype wire

### hw/rtl/cusum_core_chk.sv
// port-level checks for the cusum detector, bound to the top level
`default_nettype none

module cusum_core_chk #(
  parameter int SUM_BITS = 24
) (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_o,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic                     ready_res_o,
  input wire logic [SUM_BITS-1:0]      upper_sum_o,
  input wire logic signed [SUM_BITS:0] lower_sum_o,
  input wire logic                     anomaly_o
);

  // one item at a time: an accepted item closes the input
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  // warm-up results carry zero sums and no flag
  a_warm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ready_res_o) |->
      (upper_sum_o == '0 && lower_sum_o == '0 && !anomaly_o))
    else $error("warm-up item with nonzero result");

  // a flag needs a nonzero sum beyond the threshold
  a_flag_needs_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && anomaly_o) |-> (upper_sum_o != '0 || lower_sum_o != '0))
    else $error("anomaly flagged with both sums at zero");

  // negated lower sum is never positive
  a_lower_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (lower_sum_o == '0 || lower_sum_o[SUM_BITS]))
    else $error("lower sum is positive");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(upper_sum_o) && $stable(lower_sum_o)))
    else $error("stalled result changed");

endmodule

bind cusum_anomaly_detector_core cusum_core_chk #(
  .SUM_BITS (SUM_BITS)
) u_cusum_chk (.*);

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the cusum anomaly detector core
`timescale 1ns / 100ps

module tb_top;
  import cusum_pkg::*;

  localparam int    CYCLE_LIMIT = 400000;
  localparam int    DRAIN_WAIT  = 30;
  localparam longint SUM_CAP    = (64'd1 << SUM_BITS_DEF) - 1;

  // receiver stall patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_LONG} rx_mode_e;

  // one expected result item
  typedef struct {
    logic                   rdy;
    logic [SUM_BITS_DEF-1:0] up;
    logic signed [SUM_BITS_DEF:0] lo;
    logic                   anom;
  } cusum_result_t;

  // tracks detector state per accepted item and checks the result stream
  class cusum_scoreboard;
    bit [WLEN_W-1:0]                win_len;
    bit [DEV_W-1:0]                 dev;
    logic signed [SAMPLE_BITS_DEF-1:0] ring [WINDOW_MAX_DEF];
    int unsigned                    filled;
    int unsigned                    wr_idx;
    longint                         ring_sum;
    longint                         up_acc;
    longint                         dn_acc;
    cusum_result_t                  awaited[$];
    int                             errors;

    function new();
      win_len = DEF_WINDOW_LENGTH;
      dev     = DEF_DEVIATION;
      errors  = 0;
      clear();
    endfunction

    function void clear();
      filled   = 0;
      wr_idx   = 0;
      ring_sum = 0;
      up_acc   = 0;
      dn_acc   = 0;
    endfunction

    function void apply_config(logic idx, logic [APB_DATA_W-1:0] v);
      if (idx == REG_WINDOW_LENGTH) win_len = v[WLEN_W-1:0];
      else dev = v[DEV_W-1:0];
      clear();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function longint clamp(longint v);
      if (v < 0) return 0;
      if (v > SUM_CAP) return SUM_CAP;
      return v;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    // advance the detector by one sample and queue the result it gives
    function void note_sample(logic signed [SAMPLE_BITS_DEF-1:0] x);
      int unsigned   len;
      int unsigned   slot;
      longint        xs;
      longint        mean;
      longint        d;
      longint        k;
      longint        thr;
      cusum_result_t r;
      if (win_len == 0) len = 1;
      else if (win_len > WINDOW_MAX_DEF) len = WINDOW_MAX_DEF;
      else len = win_len;
      slot   = wr_idx % len;
      xs     = x;
      r.rdy  = 1'b0;
      r.up   = '0;
      r.lo   = '0;
      r.anom = 1'b0;
      if (filled < len) begin
        // warm-up: only fill the ring
        ring[slot] = x;
        ring_sum  += xs;
        filled++;
      end else begin
        ring_sum   = ring_sum - longint'(ring[slot]) + xs;
        ring[slot] = x;
        mean       = ring_sum / longint'(len);
        d          = xs - mean;
        k          = longint'(dev / 2);
        thr        = longint'(dev) * 5;
        up_acc     = clamp(up_acc + d - k);
        dn_acc     = clamp(dn_acc - d - k);
        r.rdy      = 1'b1;
        r.up       = up_acc[SUM_BITS_DEF-1:0];
        r.lo       = (SUM_BITS_DEF + 1)'(-dn_acc);
        r.anom     = (up_acc > thr) || (dn_acc > thr);
      end
      wr_idx = (slot + 1) % len;
      awaited.push_back(r);
    endfunction

    function void check_result(logic rdy, logic [SUM_BITS_DEF-1:0] up,
                               logic signed [SUM_BITS_DEF:0] lo, logic anom);
      cusum_result_t e;
      if (awaited.size() == 0) begin
        flag($sformatf("result with no item waiting: rdy=%0d up=%0d lo=%0d anomaly=%0d",
                       rdy, up, lo, anom));
        return;
      end
      e = awaited.pop_front();
      if (e.rdy !== rdy || e.up !== up || e.lo !== lo || e.anom !== anom)
        flag($sformatf({"result mismatch: expected rdy=%0d up=%0d lo=%0d anomaly=%0d,",
                        " got rdy=%0d up=%0d lo=%0d anomaly=%0d"},
                       e.rdy, e.up, e.lo, e.anom, rdy, up, lo, anom));
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic signed [SAMPLE_BITS_DEF-1:0]  sample_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic                               ready_res_o;
  logic        [SUM_BITS_DEF-1:0]     upper_sum_o;
  logic signed [SUM_BITS_DEF:0]       lower_sum_o;
  logic                               anomaly_o;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic        [APB_ADDR_W-1:0]       paddr;
  logic        [APB_DATA_W-1:0]       pwdata;
  logic        [APB_DATA_W-1:0]       prdata;
  logic                               pready;

  cusum_scoreboard sb;
  int              cycles;

  // sample shaping: a slowly moving level with noise around it
  int              level;
  int              spread;

  // receiver stall state
  rx_mode_e        rx_mode;
  int              rx_left;
  int              rx_hold;

  cusum_anomaly_detector_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .ready_res_o(ready_res_o),
    .upper_sum_o(upper_sum_o),
    .lower_sum_o(lower_sum_o),
    .anomaly_o  (anomaly_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // monitor: results are checked before the item of the same edge is noted,
  // a result can never belong to an item accepted at that very edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result(ready_res_o, upper_sum_o, lower_sum_o, anomaly_o);
      if (in_valid_i && in_ready_o)
        sb.note_sample(sample_i);
    end
  end

  // receiver: switches at random between stall patterns
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
      rx_hold = 0;
    end
    rx_left = rx_left - 1;
    case (rx_mode)
      RX_OPEN:   out_ready_i = 1'b1;
      RX_COIN:   out_ready_i = 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready_i = ($urandom_range(0, 3) == 0);
      default: begin
        // long stalls with open stretches in between
        if (rx_hold > 0) begin
          out_ready_i = 1'b0;
          rx_hold     = rx_hold - 1;
        end else begin
          out_ready_i = 1'b1;
          if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 30);
        end
      end
    endcase
  end

  // one apb transfer, entered and left just after a falling edge
  task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // write a register, mirror it in the scoreboard, then read it back
  task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] v);
    logic [APB_ADDR_W-1:0] addr;
    logic [APB_DATA_W-1:0] rd;
    logic [APB_DATA_W-1:0] want;
    addr = {idx, 2'b00};
    apb_access(1'b1, addr, v, rd);
    sb.apply_config(idx, v);
    apb_access(1'b0, addr, '0, rd);
    want = (idx == REG_WINDOW_LENGTH) ? APB_DATA_W'(v[WLEN_W-1:0])
                                      : APB_DATA_W'(v[DEV_W-1:0]);
    if (rd !== want)
      sb.flag($sformatf("register readback at 0x%0h: expected 0x%0h, got 0x%0h",
                        addr, want, rd));
  endtask

  // junk in the unused upper bits checks that only the field is kept
  task automatic configure(input int unsigned wlen, input int unsigned dev);
    write_reg(REG_WINDOW_LENGTH, ($urandom & ~32'h1F) | (wlen & 32'h1F));
    write_reg(REG_DEVIATION, ($urandom & 32'hFFFF_0000) | (dev & 32'hFFFF));
  endtask

  // wait for every result, then let the block go idle
  task automatic settle();
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // present one item, hold it until accepted, then drop valid for the gap, if one is given
  task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] x, input int gap);
    in_valid_i = 1'b1;
    sample_i   = x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // directed items, valid dropped after the last one
  task automatic send_seq(input logic [SAMPLE_BITS_DEF-1:0] seq[$]);
    foreach (seq[i]) send_sample(seq[i], (i == seq.size() - 1) ? 2 : (i % 3 == 2));
  endtask

  function automatic logic [SAMPLE_BITS_DEF-1:0] gen_sample();
    int v;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return SAMPLE_BITS_DEF'($urandom);
    if (pick < 12) begin
      case ($urandom_range(0, 3))
        0:       return 16'h7FFF;
        1:       return 16'h8000;
        2:       return 16'hFFFF;
        default: return 16'h0000;
      endcase
    end
    // occasional level shift, which is what the detector should catch
    if ($urandom_range(0, 99) < 3) level = int'($urandom_range(0, 65535)) - 32768;
    v = level + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return SAMPLE_BITS_DEF'(v);
  endfunction

  // random bursts of items with random gaps, valid low at the end
  task automatic run_phase(input int n);
    int sent;
    int blen;
    int gap;
    sent = 0;
    while (sent < n) begin
      blen = $urandom_range(1, 24);
      if (blen > n - sent) blen = n - sent;
      for (int j = 0; j < blen; j++) begin
        gap = 0;
        if (j == blen - 1) begin
          case ($urandom_range(0, 9))
            0, 1, 2: gap = 0;
            9:       gap = $urandom_range(10, 25);
            default: gap = $urandom_range(1, 8);
          endcase
        end
        if (sent == n - 1 && gap == 0) gap = 1;
        send_sample(gen_sample(), gap);
        sent++;
      end
    end
  endtask

  // fixed settings cover the extremes, including lengths that get clamped
  int unsigned ph_len[8] = '{1, 16, 0, 31, 17, 5, 2, 16};
  int unsigned ph_dev[8] = '{0, 65535, 100, 256, 1, 205, 65534, 0};

  initial begin
    logic [SAMPLE_BITS_DEF-1:0] seq[$];
    int unsigned wlen;
    int unsigned dev;
    sb          = new();
    cycles      = 0;
    level       = 0;
    spread      = 256;
    rx_mode     = RX_OPEN;
    rx_left     = 0;
    rx_hold     = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    out_ready_i = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults: warm-up with the extremes, then swings both ways
    seq = '{16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000,
            16'h8000, 16'h8000, 16'hFFFF, 16'h0001, 16'h0000, 16'h0100};
    send_seq(seq);
    settle();

    // length one with zero deviation: mean equals the sample, zero threshold
    configure(1, 0);
    seq = '{16'h7FFF, 16'h8000, 16'h0000, 16'h1234};
    send_seq(seq);
    settle();

    // length zero is taken as one, largest deviation
    configure(0, 65535);
    seq = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
    send_seq(seq);
    settle();

    // odd deviation: slack is truncated
    configure(2, 3);
    seq = '{16'h0010, 16'hFFF0, 16'h0400, 16'hFC00, 16'h0003};
    send_seq(seq);
    settle();

    // random phases, one setting each
    for (int p = 0; p < 8; p++) begin
      wlen = ph_len[p];
      dev  = ph_dev[p];
      if (p == 5) begin
        wlen = $urandom_range(0, 31);
        dev  = $urandom_range(0, 65535);
      end
      case ($urandom_range(0, 3))
        0:       spread = 0;
        1:       spread = 16;
        2:       spread = 256;
        default: spread = 2048;
      endcase
      level = int'($urandom_range(0, 65535)) - 32768;
      configure(wlen, dev);
      run_phase(154);
      settle();
    end

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
